>>> rtl/core/kmp_pkg.sv
// Shared constants, types and helpers for the KMP substring matcher.
`timescale 1ns / 1ps
`default_nettype none
package kmp_pkg;

	localparam int MAX_PATTERN = 64;
	localparam int MAX_TEXT    = 1048576;

	localparam int PAT_AW = $clog2(MAX_PATTERN);
	localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
	localparam int POS_W  = 21;

	localparam logic CMD_PAT = 1'b0;
	localparam logic CMD_TXT = 1'b1;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_PATTERN = 2'd1;
	localparam logic [1:0] ERR_TEXT    = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_CMP
	} st_t;

	// Failure link with guard: a link must point strictly below its own index.
	function automatic logic [LEN_W-1:0] link_f(input logic [LEN_W-1:0] v,
			input logic [LEN_W-1:0] k);
		return (v < k) ? v : '0;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/kmp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module kmp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/core/kmp_substring_matcher.sv
// KMP substring matcher: pattern load with failure-table build, then text scan.
`timescale 1ns / 1ps
// Pattern bytes (cmd 0) and text bytes (cmd 1) are taken one per request when
// start is high and busy is low. Every request gives exactly one result, shown
// for one cycle with done high; it cannot be held off. A request that needs a
// failure-link walk compares once for the start link and once more per failure
// link followed, each step being one read of the pattern and failure memories
// (registered read data); busy stays high for the walk. The first pattern byte,
// bytes against an empty pattern and dropped bytes (pattern full, text past the
// position limit) need no walk: their result shows on the next cycle and busy
// stays low, so such requests may come every cycle. KMP follows at most one
// link per advance on average. The memories need no clearing pass after reset.
`default_nettype none
module kmp_substring_matcher (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                cmd,
	input  logic [7:0]                          ch,
	input  logic                                first,
	output logic                                done,
	output logic                                matched,
	output logic signed [kmp_pkg::POS_W-1:0]    match_start,
	output logic signed [kmp_pkg::POS_W-1:0]    latest_match,
	output logic [1:0]                          error
);

	localparam int LW = kmp_pkg::LEN_W;
	localparam int PW = kmp_pkg::POS_W;
	localparam int AW = kmp_pkg::PAT_AW;

	kmp_pkg::st_t state_q, state_d;

	logic [LW-1:0] len_q, len_d;
	logic [LW-1:0] full_link_q, full_link_d;
	logic [LW-1:0] mp_q, mp_d;
	logic [PW-1:0] pos_q, pos_d;
	logic [PW-1:0] latest_q, latest_d;
	logic          latest_vld_q, latest_vld_d;
	logic [LW-1:0] k_q, k_d;
	logic [7:0]    ch_q, ch_d;
	logic          cmd_q, cmd_d;

	logic          done_q, done_d;
	logic          matched_q, matched_d;
	logic [PW-1:0] mstart_q, mstart_d;
	logic [PW-1:0] latest_out_q, latest_out_d;
	logic [1:0]    error_q, error_d;

	logic          pat_we;
	logic [AW-1:0] pat_waddr;
	logic [7:0]    pat_rdata;
	logic          fail_we;
	logic [LW-1:0] fail_waddr;
	logic [LW-1:0] fail_wdata;
	logic [LW-1:0] fail_rdata;
	logic [LW-1:0] raddr;

	logic          pat_eq;
	logic [LW-1:0] kres;
	logic [PW-1:0] hit_start;
	logic [LW-1:0] len_eff;
	logic [LW-1:0] mp_eff;
	logic [PW-1:0] pos_eff;
	logic          vld_eff;

	kmp_ram #(.WIDTH(8), .DEPTH(kmp_pkg::MAX_PATTERN)) u_pat_ram (
		.clk   (clk),
		.we    (pat_we),
		.waddr (pat_waddr),
		.wdata (ch),
		.raddr (raddr[AW-1:0]),
		.rdata (pat_rdata)
	);

	kmp_ram #(.WIDTH(LW), .DEPTH(kmp_pkg::MAX_PATTERN + 1)) u_fail_ram (
		.clk   (clk),
		.we    (fail_we),
		.waddr (fail_waddr),
		.wdata (fail_wdata),
		.raddr (raddr),
		.rdata (fail_rdata)
	);

	assign pat_eq    = (pat_rdata == ch_q);
	assign kres      = pat_eq ? LW'(k_q + 1'b1) : '0;
	assign hit_start = PW'(pos_q + PW'(1) - {{(PW-LW){1'b0}}, len_q});

	assign len_eff = first ? '0 : len_q;
	assign mp_eff  = first ? '0 : mp_q;
	assign pos_eff = first ? '0 : pos_q;
	assign vld_eff = first ? 1'b0 : latest_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= kmp_pkg::ST_IDLE;
			len_q        <= '0;
			full_link_q  <= '0;
			mp_q         <= '0;
			pos_q        <= '0;
			latest_vld_q <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			state_q      <= state_d;
			len_q        <= len_d;
			full_link_q  <= full_link_d;
			mp_q         <= mp_d;
			pos_q        <= pos_d;
			latest_vld_q <= latest_vld_d;
			done_q       <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		latest_q     <= latest_d;
		k_q          <= k_d;
		ch_q         <= ch_d;
		cmd_q        <= cmd_d;
		matched_q    <= matched_d;
		mstart_q     <= mstart_d;
		latest_out_q <= latest_out_d;
		error_q      <= error_d;
	end

	always_comb begin
		state_d      = state_q;
		len_d        = len_q;
		full_link_d  = full_link_q;
		mp_d         = mp_q;
		pos_d        = pos_q;
		latest_d     = latest_q;
		latest_vld_d = latest_vld_q;
		k_d          = k_q;
		ch_d         = ch_q;
		cmd_d        = cmd_q;
		done_d       = 1'b0;
		matched_d    = 1'b0;
		mstart_d     = '1;
		latest_out_d = '1;
		error_d      = kmp_pkg::ERR_NONE;
		pat_we       = 1'b0;
		pat_waddr    = len_eff[AW-1:0];
		fail_we      = 1'b0;
		fail_waddr   = LW'(len_q + 1'b1);
		fail_wdata   = kres;
		raddr        = k_q;

		case (state_q)
			kmp_pkg::ST_IDLE: begin
				if (start) begin
					ch_d  = ch;
					cmd_d = cmd;
					if (cmd == kmp_pkg::CMD_PAT) begin
						// every pattern byte restarts the text scan
						mp_d         = '0;
						pos_d        = '0;
						latest_vld_d = 1'b0;
						len_d        = len_eff;
						if (len_eff >= LW'(kmp_pkg::MAX_PATTERN)) begin
							done_d  = 1'b1;
							error_d = kmp_pkg::ERR_PATTERN;
						end else begin
							pat_we = 1'b1;
							if (len_eff == '0) begin
								fail_we     = 1'b1;
								fail_waddr  = LW'(1);
								fail_wdata  = '0;
								full_link_d = '0;
								len_d       = LW'(1);
								done_d      = 1'b1;
							end else begin
								// the last link written is the link of the whole prefix
								k_d     = kmp_pkg::link_f(full_link_q, len_eff);
								raddr   = k_d;
								state_d = kmp_pkg::ST_CMP;
							end
						end
					end else begin
						mp_d         = mp_eff;
						pos_d        = pos_eff;
						latest_vld_d = vld_eff;
						latest_out_d = vld_eff ? latest_q : '1;
						if (pos_eff >= PW'(kmp_pkg::MAX_TEXT)) begin
							done_d  = 1'b1;
							error_d = kmp_pkg::ERR_TEXT;
						end else if (len_q == '0) begin
							pos_d  = PW'(pos_eff + 1'b1);
							done_d = 1'b1;
						end else begin
							k_d = (mp_eff >= len_q) ?
								kmp_pkg::link_f(full_link_q, len_q) : mp_eff;
							raddr   = k_d;
							state_d = kmp_pkg::ST_CMP;
						end
					end
				end
			end
			kmp_pkg::ST_CMP: begin
				if (pat_eq || k_q == '0) begin
					state_d = kmp_pkg::ST_IDLE;
					done_d  = 1'b1;
					if (cmd_q == kmp_pkg::CMD_PAT) begin
						fail_we     = 1'b1;
						full_link_d = kres;
						len_d       = LW'(len_q + 1'b1);
					end else begin
						pos_d        = PW'(pos_q + 1'b1);
						latest_out_d = latest_vld_q ? latest_q : '1;
						if (kres == len_q) begin
							// full match: report and fall back through the whole-pattern link
							matched_d    = 1'b1;
							mstart_d     = hit_start;
							latest_d     = hit_start;
							latest_vld_d = 1'b1;
							latest_out_d = hit_start;
							mp_d         = kmp_pkg::link_f(full_link_q, len_q);
						end else begin
							mp_d = kres;
						end
					end
				end else begin
					// mismatch: follow the failure link and read again
					k_d   = kmp_pkg::link_f(fail_rdata, k_q);
					raddr = k_d;
				end
			end
			default: begin
				state_d = kmp_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy         = (state_q != kmp_pkg::ST_IDLE);
	assign done         = done_q;
	assign matched      = matched_q;
	assign match_start  = $signed(mstart_q);
	assign latest_match = $signed(latest_out_q);
	assign error        = error_q;

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(start && !busy) || $past(state_q == kmp_pkg::ST_CMP)))
		else $error("result strobe without a request or walk behind it");

	a_match_clean: assert property (@(posedge clk) disable iff (!arst_n)
		matched_q |-> (done_q && error_q == kmp_pkg::ERR_NONE))
		else $error("match flagged outside a clean result");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kmp_pkg::ST_CMP) |-> (k_q < len_q))
		else $error("failure-link walk reads at or past the pattern length");

	a_prefix_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q != '0) |-> (mp_q < len_q && full_link_q < len_q))
		else $error("matched prefix or full link not below pattern length");

endmodule
`default_nettype wire
